### hw/rtl/nearest_target_go_to_goal_steering_assert.svh
// Assertion macros for the checker file of the steering block.
// Each macro wraps one concurrent assertion on a clock and an active-low reset.
`ifndef NEAREST_TARGET_GO_TO_GOAL_STEERING_ASSERT_SVH
`define NEAREST_TARGET_GO_TO_GOAL_STEERING_ASSERT_SVH

// Same-cycle implication.
`define NTGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("steering checker: same-cycle property failed");

// Next-cycle implication.
`define NTGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("steering checker: next-cycle property failed");

`endif

### hw/rtl/ntgs_pkg.sv
// Package of the go-to-goal steering block: constants, command codes,
// the controller/datapath command and status structs and the CORDIC angle table.
// No dependencies.
`default_nettype none

package ntgs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int STEP_W           = 5;

  localparam logic [1:0] CMD_POSE = 2'd0;
  localparam logic [1:0] CMD_CAND = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] REG_SELECT  = 2'd0;
  localparam logic [1:0] REG_RADIUS  = 2'd1;
  localparam logic [1:0] REG_LIN_GAIN = 2'd2;
  localparam logic [1:0] REG_ANG_GAIN = 2'd3;

  localparam logic [33:0] DIST_NONE = 34'h3_FFFF_FFFF;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [19:0] PI_Q16     = 20'sd205887;
  localparam logic signed [17:0] CORDIC_K   = 18'sd39797;
  localparam logic signed [42:0] LIN_MAX    = 43'sd262143;
  localparam logic signed [42:0] ANG_MAX    = 43'sd262143;
  localparam logic signed [42:0] ANG_MIN    = -43'sd262144;

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic judge;
    logic catch_chk;
    logic pre;
    logic iter;
    logic mag_mul;
    logic rnd;
    logic lin_mul;
    logic ang_mul;
    logic sat;
    logic push;
  } ctrl_t;

  typedef struct packed {
    logic pose_seen;
    logic goal_valid;
    logic caught;
    logic iter_last;
    logic out_free;
  } stat_t;

  function automatic logic signed [19:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [19:0] v;
    case (idx)
      5'd0:  v = 20'sd51472;
      5'd1:  v = 20'sd30385;
      5'd2:  v = 20'sd16055;
      5'd3:  v = 20'sd8150;
      5'd4:  v = 20'sd4091;
      5'd5:  v = 20'sd2047;
      5'd6:  v = 20'sd1024;
      5'd7:  v = 20'sd512;
      5'd8:  v = 20'sd256;
      5'd9:  v = 20'sd128;
      5'd10: v = 20'sd64;
      5'd11: v = 20'sd32;
      5'd12: v = 20'sd16;
      5'd13: v = 20'sd8;
      5'd14: v = 20'sd4;
      5'd15: v = 20'sd2;
      5'd16: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ntgs_in_if.sv
// Input channel of the steering block: valid/ready handshake and one input word.
// No dependencies.
`default_nettype none

interface ntgs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [14:0] heading;
  logic [7:0]         target_id;
  logic               first_in_list;
  logic               last_in_list;

  modport source (output valid, command, pos_x, pos_y, heading, target_id,
                  first_in_list, last_in_list, input ready);
  modport sink (input valid, command, pos_x, pos_y, heading, target_id,
                first_in_list, last_in_list, output ready);
endinterface

`default_nettype wire

### hw/rtl/ntgs_out_if.sv
// Output channel of the steering block: valid/ready handshake and one result word.
// No dependencies.
`default_nettype none

interface ntgs_out_if;
  logic               valid;
  logic               ready;
  logic [17:0]        linear_speed;
  logic signed [18:0] angular_speed;
  logic               caught;
  logic [7:0]         caught_id;

  modport source (output valid, linear_speed, angular_speed, caught, caught_id,
                  input ready);
  modport sink (input valid, linear_speed, angular_speed, caught, caught_id,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/nearest_target_go_to_goal_steering.sv
// Top level of the go-to-goal steering block with nearest-target selection.
// Uses ntgs_pkg, ntgs_in_if, ntgs_out_if, ntgs_ctrl and ntgs_dp.
//
// Usage: every input word on in_i carries a command. A pose update stores the
// own position and heading and is absorbed in the accept cycle. A target
// candidate is judged against the running best of its list through the
// square, sum and judge steps; the word marked last commits the chosen
// candidate as the goal. A control tick, when a pose and a goal exist,
// produces one result word on out_o: the square and sum steps lead to the
// catch test, then, if not caught, a pre-rotation step, a vectoring CORDIC
// of CORDIC_STEPS iterations (capped at 24) on one shared shift-add unit,
// and the multiply steps on the single shared multiplier with rounding,
// saturation and output. A caught tick goes from the catch test straight
// to output. Ticks without pose or goal and unknown commands give no word.
// One word is in work at a time; in_i.ready is high only while the
// sequencer is idle. Results wait in an output register, so the block takes
// new input while a result word is still pending; if the receiver stalls and a
// second result is finished, the block holds it until the register frees.
// Reset clears pose, goal, running best and the output valid, and loads the
// registers with their defaults. Registers are written over the APB port;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
`default_nettype none

module nearest_target_go_to_goal_steering #(
  parameter int CORDIC_STEPS = ntgs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ntgs_in_if.sink          in_i,
  ntgs_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        select_closest_q;
  logic [15:0] catch_radius_q;
  logic [11:0] linear_gain_q;
  logic [11:0] angular_gain_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_closest_q <= 1'b1;
      catch_radius_q   <= 16'd2048;
      linear_gain_q    <= 12'd512;
      angular_gain_q   <= 12'd1536;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ntgs_pkg::REG_SELECT:   select_closest_q <= pwdata[0];
        ntgs_pkg::REG_RADIUS:   catch_radius_q   <= pwdata[15:0];
        ntgs_pkg::REG_LIN_GAIN: linear_gain_q    <= pwdata[11:0];
        ntgs_pkg::REG_ANG_GAIN: angular_gain_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ntgs_pkg::REG_SELECT:   prdata = {31'd0, select_closest_q};
      ntgs_pkg::REG_RADIUS:   prdata = {16'd0, catch_radius_q};
      ntgs_pkg::REG_LIN_GAIN: prdata = {20'd0, linear_gain_q};
      ntgs_pkg::REG_ANG_GAIN: prdata = {20'd0, angular_gain_q};
      default:                prdata = '0;
    endcase
  end

  ntgs_pkg::ctrl_t ctrl;
  ntgs_pkg::stat_t stat;

  ntgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .command_i  (in_i.command),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ntgs_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .command_i        (in_i.command),
    .pos_x_i          (in_i.pos_x),
    .pos_y_i          (in_i.pos_y),
    .heading_i        (in_i.heading),
    .target_id_i      (in_i.target_id),
    .first_in_list_i  (in_i.first_in_list),
    .last_in_list_i   (in_i.last_in_list),
    .select_closest_i (select_closest_q),
    .catch_radius_i   (catch_radius_q),
    .linear_gain_i    (linear_gain_q),
    .angular_gain_i   (angular_gain_q),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .linear_speed_o   (out_o.linear_speed),
    .angular_speed_o  (out_o.angular_speed),
    .caught_o         (out_o.caught),
    .caught_id_o      (out_o.caught_id)
  );

endmodule

`default_nettype wire

### hw/rtl/ntgs_ctrl.sv
// Sequencer of the steering block: walks the datapath through candidate
// judging and control-tick steps. Depends on ntgs_pkg.
`default_nettype none

module ntgs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      command_i,
  output logic                 in_ready_o,
  input  wire ntgs_pkg::stat_t stat_i,
  output ntgs_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQX   = 14'b00000000000010,
    S_SQY   = 14'b00000000000100,
    S_SUM   = 14'b00000000001000,
    S_JUDGE = 14'b00000000010000,
    S_CATCH = 14'b00000000100000,
    S_PRE   = 14'b00000001000000,
    S_ITER  = 14'b00000010000000,
    S_MAG   = 14'b00000100000000,
    S_RND   = 14'b00001000000000,
    S_LIN   = 14'b00010000000000,
    S_ANG   = 14'b00100000000000,
    S_SAT   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   is_tick_q, is_tick_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    is_tick_d = is_tick_q;
    ctrl_o    = '0;
    ctrl_o.load = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == ntgs_pkg::CMD_CAND) begin
            state_d   = S_SQX;
            is_tick_d = 1'b0;
          end else if (command_i == ntgs_pkg::CMD_TICK && stat_i.pose_seen &&
                       stat_i.goal_valid) begin
            state_d   = S_SQX;
            is_tick_d = 1'b1;
          end
        end
      end
      S_SQX: begin
        ctrl_o.sq_x = 1'b1;
        state_d     = S_SQY;
      end
      S_SQY: begin
        ctrl_o.sq_y = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        ctrl_o.sum = 1'b1;
        state_d    = is_tick_q ? S_CATCH : S_JUDGE;
      end
      S_JUDGE: begin
        ctrl_o.judge = 1'b1;
        state_d      = S_IDLE;
      end
      S_CATCH: begin
        ctrl_o.catch_chk = 1'b1;
        state_d          = stat_i.caught ? S_OUT : S_PRE;
      end
      S_PRE: begin
        ctrl_o.pre = 1'b1;
        state_d    = S_ITER;
      end
      S_ITER: begin
        ctrl_o.iter = 1'b1;
        if (stat_i.iter_last) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        ctrl_o.mag_mul = 1'b1;
        state_d        = S_RND;
      end
      S_RND: begin
        ctrl_o.rnd = 1'b1;
        state_d    = S_LIN;
      end
      S_LIN: begin
        ctrl_o.lin_mul = 1'b1;
        state_d        = S_ANG;
      end
      S_ANG: begin
        ctrl_o.ang_mul = 1'b1;
        state_d        = S_SAT;
      end
      S_SAT: begin
        ctrl_o.sat = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.push = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_tick_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_tick_q <= is_tick_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ntgs_dp.sv
// Datapath of the steering block: pose, list and goal state, one shared
// multiplier, the iterative CORDIC and the output register. Depends on ntgs_pkg.
`default_nettype none

module ntgs_dp #(
  parameter int CORDIC_STEPS = ntgs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ntgs_pkg::ctrl_t    ctrl_i,
  output ntgs_pkg::stat_t         stat_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [15:0]        pos_x_i,
  input  wire logic [15:0]        pos_y_i,
  input  wire logic signed [14:0] heading_i,
  input  wire logic [7:0]         target_id_i,
  input  wire logic               first_in_list_i,
  input  wire logic               last_in_list_i,
  input  wire logic               select_closest_i,
  input  wire logic [15:0]        catch_radius_i,
  input  wire logic [11:0]        linear_gain_i,
  input  wire logic [11:0]        angular_gain_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [17:0]             linear_speed_o,
  output logic signed [18:0]      angular_speed_o,
  output logic                    caught_o,
  output logic [7:0]              caught_id_o
);

  localparam int NSTEPS = (CORDIC_STEPS > ntgs_pkg::MAX_STEPS) ?
                          ntgs_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [ntgs_pkg::STEP_W-1:0] LAST_STEP = ntgs_pkg::STEP_W'(NSTEPS - 1);

  // Architectural state.
  logic [15:0]        own_x_q, own_y_q, goal_x_q, goal_y_q, best_x_q, best_y_q;
  logic signed [14:0] own_head_q;
  logic [7:0]         goal_id_q, best_id_q;
  logic               pose_seen_q, goal_valid_q;
  logic [33:0]        best_d_q;

  // Latched candidate and work registers.
  logic [15:0]        px_q, py_q;
  logic [7:0]         id_q;
  logic               first_q, last_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [42:0] p_q;
  logic [33:0]        acc_q, d_q;
  logic signed [23:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic [ntgs_pkg::STEP_W-1:0] i_q;
  logic [17:0]        mag_q;
  logic signed [17:0] diff_q;

  logic [17:0]        res_lin_q;
  logic signed [18:0] res_ang_q;
  logic               res_caught_q;
  logic [7:0]         res_id_q;
  logic               out_valid_q;

  // Shared multiplier operands.
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl_i.sq_x) begin
      mul_a = 25'(dx_q);
      mul_b = 18'(dx_q);
    end else if (ctrl_i.sq_y) begin
      mul_a = 25'(dy_q);
      mul_b = 18'(dy_q);
    end else if (ctrl_i.sum) begin
      mul_a = $signed({9'd0, catch_radius_i});
      mul_b = $signed({2'd0, catch_radius_i});
    end else if (ctrl_i.mag_mul) begin
      mul_a = 25'(cx_q);
      mul_b = ntgs_pkg::CORDIC_K;
    end else if (ctrl_i.lin_mul) begin
      mul_a = $signed({7'd0, mag_q});
      mul_b = $signed({6'd0, linear_gain_i});
    end else if (ctrl_i.ang_mul) begin
      mul_a = 25'(diff_q);
      mul_b = $signed({6'd0, angular_gain_i});
    end
  end

  assign mul_p = mul_a * mul_b;

  // Candidate selection.
  logic [33:0] best_eff;
  logic        take;
  assign best_eff = first_q ? ntgs_pkg::DIST_NONE : best_d_q;
  assign take     = select_closest_i ? (d_q < best_eff) : (best_eff == ntgs_pkg::DIST_NONE);

  logic caught;
  assign caught = d_q <= {2'd0, p_q[31:0]};

  // CORDIC pre-rotation and one micro-rotation.
  logic signed [23:0] xs, ys, shx, shy;
  assign xs  = {{3{dx_q[16]}}, dx_q, 4'd0};
  assign ys  = {{3{dy_q[16]}}, dy_q, 4'd0};
  assign shx = cx_q >>> i_q;
  assign shy = cy_q >>> i_q;

  // Angle rounding and heading error.
  logic signed [19:0] z_rnd;
  logic signed [17:0] ang_e, head_e, diff_raw, diff_wrap;
  assign z_rnd    = (cz_q + 20'sd8) >>> 4;
  assign ang_e    = 18'(z_rnd);
  assign head_e   = 18'(own_head_q);
  assign diff_raw = ang_e - head_e;
  always_comb begin
    if (diff_raw > ntgs_pkg::PI_Q12) begin
      diff_wrap = diff_raw - ntgs_pkg::TWO_PI_Q12;
    end else if (diff_raw < -ntgs_pkg::PI_Q12) begin
      diff_wrap = diff_raw + ntgs_pkg::TWO_PI_Q12;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  // Round half up by 256, then saturate; the magnitude rounds half up by 2^20.
  logic signed [42:0] p_rnd, mag_rnd;
  logic [17:0]        lin_sat;
  logic signed [18:0] ang_sat;
  assign p_rnd   = (p_q + 43'sd128) >>> 8;
  assign mag_rnd = (p_q + 43'sd524288) >>> 20;
  always_comb begin
    if (p_rnd > ntgs_pkg::LIN_MAX) begin
      lin_sat = 18'(ntgs_pkg::LIN_MAX);
    end else if (p_rnd < 43'sd0) begin
      lin_sat = '0;
    end else begin
      lin_sat = p_rnd[17:0];
    end
    if (p_rnd > ntgs_pkg::ANG_MAX) begin
      ang_sat = 19'(ntgs_pkg::ANG_MAX);
    end else if (p_rnd < ntgs_pkg::ANG_MIN) begin
      ang_sat = 19'(ntgs_pkg::ANG_MIN);
    end else begin
      ang_sat = p_rnd[18:0];
    end
  end

  logic [15:0] ref_x, ref_y;
  assign ref_x = (command_i == ntgs_pkg::CMD_CAND) ? pos_x_i : goal_x_q;
  assign ref_y = (command_i == ntgs_pkg::CMD_CAND) ? pos_y_i : goal_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_x_q      <= '0;
      own_y_q      <= '0;
      own_head_q   <= '0;
      pose_seen_q  <= 1'b0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_id_q    <= '0;
      goal_valid_q <= 1'b0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      best_id_q    <= '0;
      best_d_q     <= ntgs_pkg::DIST_NONE;
      out_valid_q  <= 1'b0;
      i_q          <= '0;
    end else begin
      if (ctrl_i.load && command_i == ntgs_pkg::CMD_POSE) begin
        own_x_q     <= pos_x_i;
        own_y_q     <= pos_y_i;
        own_head_q  <= heading_i;
        pose_seen_q <= 1'b1;
      end
      if (ctrl_i.judge) begin
        if (take) begin
          best_x_q  <= px_q;
          best_y_q  <= py_q;
          best_id_q <= id_q;
        end
        if (last_q) begin
          goal_x_q     <= take ? px_q : best_x_q;
          goal_y_q     <= take ? py_q : best_y_q;
          goal_id_q    <= take ? id_q : best_id_q;
          goal_valid_q <= 1'b1;
          best_d_q     <= ntgs_pkg::DIST_NONE;
        end else if (take) begin
          best_d_q <= d_q;
        end else begin
          best_d_q <= best_eff;
        end
      end
      if (ctrl_i.catch_chk && caught) begin
        goal_valid_q <= 1'b0;
      end
      if (ctrl_i.pre) begin
        i_q <= '0;
      end else if (ctrl_i.iter) begin
        i_q <= i_q + 1'b1;
      end
      if (ctrl_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      id_q    <= target_id_i;
      first_q <= first_in_list_i;
      last_q  <= last_in_list_i;
      dx_q    <= $signed({1'b0, ref_x}) - $signed({1'b0, own_x_q});
      dy_q    <= $signed({1'b0, ref_y}) - $signed({1'b0, own_y_q});
    end
    if (ctrl_i.sq_x || ctrl_i.sq_y || ctrl_i.sum || ctrl_i.mag_mul ||
        ctrl_i.lin_mul || ctrl_i.ang_mul) begin
      p_q <= mul_p;
    end
    if (ctrl_i.sq_y) begin
      acc_q <= p_q[33:0];
    end
    if (ctrl_i.sum) begin
      d_q <= acc_q + p_q[33:0];
    end
    if (ctrl_i.catch_chk) begin
      res_lin_q    <= '0;
      res_ang_q    <= '0;
      res_caught_q <= 1'b1;
      res_id_q     <= goal_id_q;
    end
    if (ctrl_i.pre) begin
      if (xs < 24'sd0) begin
        cz_q <= (ys >= 24'sd0) ? ntgs_pkg::PI_Q16 : -ntgs_pkg::PI_Q16;
        cx_q <= -xs;
        cy_q <= -ys;
      end else begin
        cz_q <= '0;
        cx_q <= xs;
        cy_q <= ys;
      end
    end
    if (ctrl_i.iter) begin
      if (cy_q > 24'sd0) begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        cz_q <= cz_q + ntgs_pkg::atan_q16(i_q);
      end else if (cy_q < 24'sd0) begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        cz_q <= cz_q - ntgs_pkg::atan_q16(i_q);
      end
    end
    if (ctrl_i.rnd) begin
      mag_q  <= mag_rnd[17:0];
      diff_q <= diff_wrap;
    end
    if (ctrl_i.ang_mul) begin
      res_lin_q <= lin_sat;
    end
    if (ctrl_i.sat) begin
      res_ang_q    <= ang_sat;
      res_caught_q <= 1'b0;
      res_id_q     <= '0;
    end
    if (ctrl_i.push) begin
      linear_speed_o  <= res_lin_q;
      angular_speed_o <= res_ang_q;
      caught_o        <= res_caught_q;
      caught_id_o     <= res_id_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stat_o.pose_seen  = pose_seen_q;
  assign stat_o.goal_valid = goal_valid_q;
  assign stat_o.caught     = caught;
  assign stat_o.iter_last  = (i_q == LAST_STEP);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

### hw/rtl/ntgs_checker.sv
// Port-level checker of the steering block and its bind to the top level.
// Depends on nearest_target_go_to_goal_steering_assert.svh.
`default_nettype none

`include "nearest_target_go_to_goal_steering_assert.svh"

module ntgs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [17:0]        linear_speed_i,
  input wire logic signed [18:0] angular_speed_i,
  input wire logic               caught_i,
  input wire logic [7:0]         caught_id_i
);

  // A caught word carries zero speeds.
  `NTGS_ASSERT_IMP(a_caught_zero, clk_i, rst_ni, out_valid_i && caught_i, linear_speed_i == 18'd0 && angular_speed_i == 19'sd0)

  // A word that is not caught carries no id.
  `NTGS_ASSERT_IMP(a_id_zero, clk_i, rst_ni, out_valid_i && !caught_i, caught_id_i == 8'd0)

  // A stalled word holds.
  `NTGS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(linear_speed_i) && $stable(angular_speed_i) && $stable(caught_i) && $stable(caught_id_i))

endmodule

bind nearest_target_go_to_goal_steering ntgs_checker u_ntgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .linear_speed_i  (out_o.linear_speed),
  .angular_speed_i (out_o.angular_speed),
  .caught_i        (out_o.caught),
  .caught_id_i     (out_o.caught_id)
);

`default_nettype wire
